FILE: rtl/core/sphpga_pkg.sv
// Package for the SPH pressure-gradient accumulator.
// Shared types and constants for the front and back parts.
package sphpga_pkg;
  localparam int unsigned WordW  = 32;
  localparam int unsigned RhoW   = 31;
  localparam int unsigned InW    = 350; // 11 payload fields (349 bits) plus the last marker
  localparam int unsigned OutW   = 96;
  localparam logic signed [63:0] S32Max = 64'sd2147483647;
  localparam logic signed [63:0] S32Min = -64'sd2147483648;

  // Classified pair from front to back
  typedef struct packed {
    logic signed [31:0] ci;
    logic signed [31:0] cj;
    logic [30:0]        mass;
    logic signed [31:0] gix, giy, giz, gjx, gjy, gjz;
    logic               last;
    logic               ovf;
  } pair_t;
endpackage

FILE: rtl/core/sphpga_div.sv
// Restoring shifted divider: q = floor(n * 2^(2F) / d), capped at 2^32.
// One quotient bit a cycle; depends on sphpga_pkg.
module sphpga_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [61:0] den,
  output logic        busy,
  output logic [32:0] quo
);
  import sphpga_pkg::*;
  localparam int unsigned Steps = 32 + 2 * FRAC_BITS;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic [CntW-1:0] cnt;
  logic [31:0]     nsh;
  logic [63:0]     rem;
  logic [63:0]     rsh;
  logic            bitq;

  // Shift in the next numerator bit and compare
  always_comb begin
    rsh  = {rem[62:0], nsh[31]};
    bitq = (rsh >= {2'b00, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      busy <= 1'b0;
    end else if (start) begin
      cnt <= '0;
      busy <= 1'b1;
      nsh <= num;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      nsh <= {nsh[30:0], 1'b0};
      rem <= bitq ? rsh - {2'b00, den} : rsh;
      if (quo[32]) quo <= quo;
      else if ({quo[31:0], bitq} > 33'h1_0000_0000) quo <= 33'h1_0000_0000;
      else quo <= {quo[31:0], bitq};
      cnt <= cnt + 1'b1;
      if (cnt == CntW'(Steps - 1)) busy <= 1'b0;
    end
  end
endmodule

FILE: rtl/core/sphpga_front.sv
// Front part: takes pairs and forms both pressure coefficients with one
// shared divider. Depends on sphpga_pkg and sphpga_div.
module sphpga_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [sphpga_pkg::InW-1:0] in_data,
  output logic                q_valid,
  input  logic                q_ready,
  output sphpga_pkg::pair_t   q_pair
);
  import sphpga_pkg::*;
  localparam logic [2:0] SIdle = 3'd0, SMulI = 3'd1, SDivI = 3'd2,
                         SMulJ = 3'd3, SDivJ = 3'd4, SOut = 3'd5;

  logic [2:0] state;
  logic [InW-1:0] hold;
  logic signed [31:0] ci;
  logic ovf;
  logic [61:0] rho_sq;
  logic div_start, div_busy;
  logic [32:0] quo;
  logic signed [31:0] p_cur;
  logic [30:0] rho_cur;
  logic signed [31:0] cval;
  logic cflag;
  logic signed [33:0] sq;

  assign p_cur   = (state == SMulI || state == SDivI) ? hold[31:0] : hold[94:63];
  assign rho_cur = (state == SMulI || state == SDivI) ? hold[62:32] : hold[125:95];

  sphpga_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(p_cur[31] ? 32'(-p_cur) : 32'(p_cur)), .den(rho_sq),
    .busy(div_busy), .quo(quo)
  );

  // Signed, saturated coefficient from the divider result and special cases
  always_comb begin
    cflag = 1'b0;
    sq = p_cur[31] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (p_cur == 0) cval = '0;
    else if (rho_cur == 0) begin
      cflag = 1'b1;
      cval = p_cur[31] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (sq > 34'sh0_7fff_ffff) begin
      cflag = 1'b1; cval = 32'sh7fff_ffff;
    end else if (sq < -34'sh0_8000_0000) begin
      cflag = 1'b1; cval = 32'sh8000_0000;
    end else cval = sq[31:0];
  end

  assign in_ready  = (state == SIdle);
  assign q_valid   = (state == SOut);
  assign div_start = (state == SMulI || state == SMulJ);
  assign q_pair = '{ci: ci, cj: cval, mass: hold[156:126],
    gix: hold[188:157], giy: hold[220:189], giz: hold[252:221],
    gjx: hold[284:253], gjy: hold[316:285], gjz: hold[348:317],
    last: hold[349], ovf: ovf};

  // Sequence the two divisions
  always_ff @(posedge clk) begin
    if (rst) state <= SIdle;
    else begin
      unique case (state)
        SIdle: if (in_valid) begin
          hold <= in_data;
          ovf <= 1'b0;
          state <= SMulI;
        end
        SMulI, SMulJ: state <= state + 3'd1;
        SDivI: if (!div_busy) begin
          ci <= cval; ovf <= cflag;
          state <= SMulJ;
        end
        SDivJ: if (!div_busy) begin
          ovf <= ovf | cflag;
          state <= SOut;
        end
        SOut: if (q_ready) state <= SIdle;
        default: state <= SIdle;
      endcase
    end
  end

  // Square the density into a register ahead of the divider start
  always_ff @(posedge clk) begin
    if (state == SIdle && in_valid) rho_sq <= 62'(in_data[62:32]) * 62'(in_data[62:32]);
    else if (state == SDivI && !div_busy) rho_sq <= 62'(hold[125:95]) * 62'(hold[125:95]);
  end
endmodule

FILE: rtl/core/sphpga_back.sv
// Back part: products, saturation and the accumulator, one axis a step.
// Depends on sphpga_pkg.
module sphpga_back #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned ACC_WIDTH = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  sphpga_pkg::pair_t q_pair,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [sphpga_pkg::OutW-1:0] out_data,
  output logic              out_sat
);
  import sphpga_pkg::*;
  localparam logic [1:0] SIdle = 2'd0, SMul = 2'd1, SMass = 2'd2, SAcc = 2'd3;
  localparam logic signed [ACC_WIDTH-1:0] AccMax = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] AccMin = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  // Wide enough for accumulator widths up to 65 bits and any mass product
  localparam int unsigned DW = 66;

  logic [1:0] state;
  logic [1:0] axis;
  pair_t pr;
  logic signed [ACC_WIDTH-1:0] acc [3];
  logic ovf;
  logic signed [63:0] ti, tj, fsum, dlt;
  logic signed [31:0] f;
  logic fsat;
  logic signed [31:0] gi, gj;
  logic signed [DW-1:0] diff;
  logic signed [ACC_WIDTH-1:0] accn;
  logic asat;

  // Truncating fixed-point product on magnitudes
  function automatic logic signed [63:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic [31:0] ma, mb;
    logic [63:0] m;
    ma = a[31] ? 32'(-a) : 32'(a);
    mb = b[31] ? 32'(-b) : 32'(b);
    m = (64'(ma) * 64'(mb)) >> FRAC_BITS;
    return (a[31] ^ b[31]) ? -$signed(m) : $signed(m);
  endfunction

  always_comb begin
    unique case (axis)
      2'd0: begin gi = pr.gix; gj = pr.gjx; end
      2'd1: begin gi = pr.giy; gj = pr.gjy; end
      default: begin gi = pr.giz; gj = pr.gjz; end
    endcase
    fsat = 1'b0;
    fsum = ti + tj;
    if (fsum > S32Max) begin fsat = 1'b1; f = 32'sh7fff_ffff; end
    else if (fsum < S32Min) begin fsat = 1'b1; f = 32'sh8000_0000; end
    else f = fsum[31:0];
    diff = DW'(acc[axis]) - DW'(dlt);
    asat = 1'b0;
    if (diff > DW'(AccMax)) begin asat = 1'b1; accn = AccMax; end
    else if (diff < DW'(AccMin)) begin asat = 1'b1; accn = AccMin; end
    else accn = diff[ACC_WIDTH-1:0];
  end

  // Saturate each sum to 32 bits for output
  function automatic logic [31:0] sat_out(input logic signed [ACC_WIDTH-1:0] v);
    if (v > $signed(ACC_WIDTH'(S32Max))) return 32'h7fff_ffff;
    if (v < $signed(ACC_WIDTH'(S32Min))) return 32'h8000_0000;
    return v[31:0];
  endfunction
  function automatic logic big(input logic signed [ACC_WIDTH-1:0] v);
    return (v > $signed(ACC_WIDTH'(S32Max))) || (v < $signed(ACC_WIDTH'(S32Min)));
  endfunction

  assign q_ready = (state == SIdle) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      out_valid <= 1'b0;
      ovf <= 1'b0;
      axis <= '0;
      for (int k = 0; k < 3; k++) acc[k] <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        SIdle: if (q_valid && q_ready) begin
          pr <= q_pair;
          ovf <= ovf | q_pair.ovf;
          axis <= '0;
          state <= SMul;
        end
        SMul: begin
          ti <= mulq(pr.ci, gi);
          tj <= mulq(pr.cj, gj);
          state <= SMass;
        end
        SMass: begin
          dlt <= mulq($signed({1'b0, pr.mass}), f);
          ovf <= ovf | fsat;
          state <= SAcc;
        end
        SAcc: begin
          if (axis == 2'd2) begin
            state <= SIdle;
            if (pr.last) begin
              // Emit the particle and clear for the next one
              out_valid <= 1'b1;
              out_data <= {sat_out(accn), sat_out(acc[1]), sat_out(acc[0])};
              out_sat <= ovf | asat | big(acc[0]) | big(acc[1]) | big(accn);
              for (int k = 0; k < 3; k++) acc[k] <= '0;
              ovf <= 1'b0;
            end else begin
              acc[axis] <= accn;
              ovf <= ovf | asat;
            end
          end else begin
            acc[axis] <= accn;
            ovf <= ovf | asat;
            axis <= axis + 2'd1;
            state <= SMul;
          end
        end
        default: state <= SIdle;
      endcase
    end
  end
endmodule

FILE: rtl/core/sph_pressure_gradient_accumulator_unit.sv
// SPH pressure-gradient accumulator, top level.
// One pair at a time runs through the shared bit-serial coefficient divider, so
// the input takes a new pair only after the front part has handed off the last;
// the back part overlaps the next division.
// Reset (rst, synchronous) clears the accumulator, flag and handshakes.
module sph_pressure_gradient_accumulator_unit #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned ACC_WIDTH = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pressure_i, density_i, pressure_j, density_j, mass_j, grad_i_x..z, grad_j_x..z
  input  logic [351:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // accel_x, accel_y, accel_z
  output logic [95:0]  m_axis_tdata,
  // saturated
  output logic         m_axis_tuser
);
  import sphpga_pkg::*;
  logic q_valid, q_ready;
  pair_t q_pair;
  logic [InW-1:0] din;

  // Carry the last marker with the payload
  assign din = {s_axis_tlast, s_axis_tdata[348:0]};

  sphpga_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(din), .q_valid(q_valid), .q_ready(q_ready), .q_pair(q_pair)
  );

  sphpga_back #(.FRAC_BITS(FRAC_BITS), .ACC_WIDTH(ACC_WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_pair(q_pair),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_sat(m_axis_tuser)
  );
endmodule

FILE: rtl/core/sphpga_checker.sv
// Port-level checker for the accumulator, bound to the top level.
// Depends on nothing beyond the top level's ports.
module sphpga_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic m_axis_tuser
);
  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // No result straight out of reset
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result after reset");
  // An accepted pair takes the input out of ready next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("front took two pairs back to back");
endmodule

bind sph_pressure_gradient_accumulator_unit sphpga_checker u_chk (.*);

FILE: sim/tb.sv
// Self-checking bench for sph_pressure_gradient_accumulator_unit.
// Drives neighbour pairs into the stream input and checks each emitted acceleration
// against a bit-true predictor held in a small scoreboard class. Needs sphpga_pkg.
module tb;
  import sphpga_pkg::*;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned AccWidth  = 48;
  localparam int          NumRandom = 800;
  localparam longint      CycleCap  = 2000000;

  typedef struct {
    logic signed [31:0] p_i;
    logic [30:0]        rho_i;
    logic signed [31:0] p_j;
    logic [30:0]        rho_j;
    logic [30:0]        mass;
    logic signed [31:0] gi [3];
    logic signed [31:0] gj [3];
    logic               last;
  } stim_pair_t;

  typedef struct {
    logic signed [31:0] a [3];
    logic               sat;
  } accel_t;

  // Predicts the summed acceleration and holds the pending results
  class accel_scoreboard;
    longint  acc_sum [3];
    bit      ovf_seen;
    bit      hit;
    accel_t  pending [$];
    int      errors;

    function new();
      acc_sum = '{0, 0, 0};
      ovf_seen = 0;
      errors = 0;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) begin
        hit = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        hit = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint unsigned magn(longint v);
      return (v < 0) ? 64'd0 - longint'(v) : longint'(v);
    endfunction

    // floor(n * 2^sh / d) by restoring division, quotient capped at 2^32
    function longint unsigned shifted_quot(longint unsigned n, int sh, longint unsigned d);
      longint unsigned r, q, b;
      longint unsigned cap;
      r = 0;
      q = 0;
      cap = 64'h1_0000_0000;
      for (int k = 0; k < 32 + sh; k++) begin
        b = (k < 32) ? ((n >> (31 - k)) & 1) : 0;
        r = (r << 1) | b;
        b = 0;
        if (r >= d) begin
          r = r - d;
          b = 1;
        end
        if (q >= cap) q = cap;
        else begin
          q = (q << 1) | b;
          if (q > cap) q = cap;
        end
      end
      return q;
    endfunction

    // pressure over density squared, with zero density clipped to the sign extreme
    function longint pressure_coeff(longint p, longint unsigned rho);
      longint v;
      if (p == 0) return 0;
      if (rho == 0) begin
        hit = 1;
        return (p < 0) ? -64'sd2147483648 : 64'sd2147483647;
      end
      v = longint'(shifted_quot(magn(p), 2 * FracBits, rho * rho));
      if (p < 0) v = -v;
      return clip32(v);
    endfunction

    function longint qmul(longint a, longint b);
      longint unsigned m;
      m = (magn(a) * magn(b)) >> FracBits;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function longint acc_subtract(longint acc, longint d);
      longint amax, amin;
      amax = (longint'(1) <<< (AccWidth - 1)) - 1;
      amin = -amax - 1;
      if (d > 0 && acc < amin + d) begin
        hit = 1;
        return amin;
      end
      if (d < 0 && acc > amax + d) begin
        hit = 1;
        return amax;
      end
      return acc - d;
    endfunction

    // Accumulate one accepted pair; queue a result when it closes the particle
    function void note_pair(stim_pair_t pr);
      longint ci, cj, f;
      accel_t res;
      hit = ovf_seen;
      ci = pressure_coeff(longint'(pr.p_i), longint'(pr.rho_i));
      cj = pressure_coeff(longint'(pr.p_j), longint'(pr.rho_j));
      for (int k = 0; k < 3; k++) begin
        f = clip32(qmul(ci, longint'(pr.gi[k])) + qmul(cj, longint'(pr.gj[k])));
        acc_sum[k] = acc_subtract(acc_sum[k], qmul(longint'(pr.mass), f));
      end
      ovf_seen = hit;
      if (pr.last) begin
        for (int k = 0; k < 3; k++) begin
          res.a[k] = 32'(clip32(acc_sum[k]));
          acc_sum[k] = 0;
        end
        res.sat = hit;
        ovf_seen = 0;
        pending.push_back(res);
      end
    endfunction

    // Compare one emitted result with the oldest prediction
    function void check_result(logic [95:0] data, logic sat);
      accel_t exp_r;
      string nm [3];
      nm = '{"accel_x", "accel_y", "accel_z"};
      if (pending.size() == 0) begin
        $error("result with nothing pending: data=%h saturated=%0b", data, sat);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      for (int k = 0; k < 3; k++)
        if (data[32*k +: 32] !== exp_r.a[k]) begin
          $error("%s expected %0d got %0d", nm[k], exp_r.a[k], $signed(data[32*k +: 32]));
          errors++;
        end
      if (sat !== exp_r.sat) begin
        $error("saturated expected %0b got %0b", exp_r.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  // pressure_i, density_i, pressure_j, density_j, mass_j, grad_i_x..z, grad_j_x..z
  logic [351:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  // accel_x, accel_y, accel_z
  logic [95:0]  m_axis_tdata;
  // saturated
  logic         m_axis_tuser;

  accel_scoreboard sb = new();
  stim_pair_t      cur;
  longint          cycles = 0;
  bit              calm = 0;
  bit              took_result = 0;
  int              stall = 0;

  sph_pressure_gradient_accumulator_unit #(
    .FRAC_BITS(FracBits),
    .ACC_WIDTH(AccWidth)
  ) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Check each output transaction
  always @(posedge clk) begin
    took_result <= !rst && m_axis_tvalid && m_axis_tready;
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Stall the result side at random
  always @(negedge clk) begin
    if (stall > 0) begin
      m_axis_tready <= 0;
      stall <= stall - 1;
    end else begin
      m_axis_tready <= 1;
      if (took_result && !calm) stall <= $urandom_range(0, 6);
    end
  end

  function automatic logic [31:0] pick_signed();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h7fff_ffff;
      1: v = 32'h8000_0000;
      2: v = 32'h0;
      3, 4: v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h0010_0000);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [30:0] pick_positive(bit allow_zero);
    case ($urandom_range(0, 9))
      0: return allow_zero ? 31'h0 : 31'h1;
      1: return 31'h1;
      2: return 31'h7fff_ffff;
      3: return 31'($urandom);
      default: return 31'($urandom_range(32'h0000_4000, 32'h0010_0000));
    endcase
  endfunction

  function automatic stim_pair_t random_pair(bit last);
    stim_pair_t pr;
    pr.p_i = pick_signed();
    pr.rho_i = pick_positive(1);
    pr.p_j = pick_signed();
    pr.rho_j = pick_positive(1);
    pr.mass = pick_positive(1);
    for (int k = 0; k < 3; k++) begin
      pr.gi[k] = pick_signed();
      pr.gj[k] = pick_signed();
    end
    pr.last = last;
    return pr;
  endfunction

  // Present one pair after a random gap and hold it until accepted
  task automatic send_pair(stim_pair_t pr);
    int gap;
    logic [351:0] d;
    gap = calm ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid = 0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    d = '0;
    d[31:0]    = pr.p_i;
    d[62:32]   = pr.rho_i;
    d[94:63]   = pr.p_j;
    d[125:95]  = pr.rho_j;
    d[156:126] = pr.mass;
    for (int k = 0; k < 3; k++) begin
      d[157 + 32*k +: 32] = pr.gi[k];
      d[253 + 32*k +: 32] = pr.gj[k];
    end
    s_axis_tdata = d;
    s_axis_tlast = pr.last;
    s_axis_tvalid = 1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_pair(pr);
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int group;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: unit values, zero pressure, zero density, extremes, zero mass
    cur = random_pair(1);
    cur.p_i = 32'h0001_0000; cur.rho_i = 31'h1_0000;
    cur.p_j = 32'h0001_0000; cur.rho_j = 31'h1_0000; cur.mass = 31'h1_0000;
    cur.gi = '{32'h0001_0000, -32'sh0001_0000, 0};
    cur.gj = '{32'h0000_8000, 32'h0002_0000, -32'sh0000_4000};
    send_pair(cur);
    cur.p_i = 0; cur.p_j = 0; cur.rho_i = 0; cur.rho_j = 0;
    send_pair(cur);
    cur.p_i = 32'h8000_0000; cur.rho_i = 0;
    cur.p_j = 32'h7fff_ffff; cur.rho_j = 0;
    send_pair(cur);
    cur.p_i = 32'h7fff_ffff; cur.rho_i = 31'h1; cur.mass = 31'h7fff_ffff;
    cur.gi = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
    cur.gj = '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
    cur.last = 0;
    repeat (4) send_pair(cur);
    cur.last = 1;
    send_pair(cur);
    // saturation flag clears with the particle
    cur = random_pair(1);
    cur.mass = 0;
    send_pair(cur);
    cur.p_i = 32'h8000_0000; cur.p_j = 32'h8000_0000;
    cur.rho_i = 31'h7fff_ffff; cur.rho_j = 31'h7fff_ffff; cur.mass = 31'h7fff_ffff;
    send_pair(cur);
    for (int n = 0; n < 8; n++) send_pair(random_pair(n % 3 == 2));
    cur = random_pair(1);
    send_pair(cur);

    // Random particles of one to eight neighbours
    sent = 0;
    while (sent < NumRandom) begin
      if ((sent / 100) % 3 == 2) calm = 1;
      else calm = 0;
      group = $urandom_range(1, 8);
      for (int n = 0; n < group; n++) begin
        send_pair(random_pair(n == group - 1));
        sent++;
      end
      if (sent >= NumRandom / 2 && sent < NumRandom / 2 + 8) drain();
    end
    calm = 0;

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
